// ===== rtl/core/vvou_pkg.sv =====
// Package for the voxel visibility and occlusion unit: opcodes, offset tables, tile lookup.
`default_nettype none

package vvou_pkg;

    // Default edge length of the occupancy cube.
    localparam int VVOU_EDGE = 32;

    // Width of a neighbour coordinate: a 5-bit position plus or minus one, with headroom
    // so that minus one wraps far above any legal edge length.
    localparam int CW = 7;

    // Number of faces that have a ring of neighbours.
    localparam int NUM_FACES = 6;

    // Last step index of the neighbour walk for each query kind.
    localparam logic [2:0] VIS_LAST  = 3'd5;
    localparam logic [2:0] RING_LAST = 3'd7;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_VIS   = 2'd2,
        OP_OCC   = 2'd3
    } t_opcode;

    // Offsets are packed as {dx, dy, dz}, two bits each in two's complement.
    typedef logic [5:0] t_ofs;

    // Ring of eight voxels one layer out from each face, in neighbour map bit order.
    localparam t_ofs RING_OFS [0:NUM_FACES-1][0:7] = '{
        '{6'b110111, 6'b000111, 6'b010111, 6'b010100,
          6'b010101, 6'b000101, 6'b110101, 6'b110100},
        '{6'b010111, 6'b000111, 6'b110111, 6'b110011,
          6'b111111, 6'b001111, 6'b011111, 6'b010011},
        '{6'b010101, 6'b010100, 6'b010111, 6'b010011,
          6'b011111, 6'b011100, 6'b011101, 6'b010001},
        '{6'b110101, 6'b000101, 6'b010101, 6'b010001,
          6'b011101, 6'b001101, 6'b111101, 6'b110001},
        '{6'b110111, 6'b110100, 6'b110101, 6'b110001,
          6'b111101, 6'b111100, 6'b111111, 6'b110011},
        '{6'b111101, 6'b001101, 6'b011101, 6'b011100,
          6'b011111, 6'b001111, 6'b111111, 6'b111100}
    };

    // The six face neighbours; the last two entries are never walked.
    localparam t_ofs VIS_OFS [0:7] = '{
        6'b110000, 6'b010000, 6'b001100, 6'b000100,
        6'b000011, 6'b000001, 6'b000000, 6'b000000
    };

    // Lower-corner tile lookup.
    function automatic logic [3:0] row_lookup(input logic [3:0] idx);
        logic [3:0] res;
        case (idx)
            4'd7:    res = 4'd15;
            4'd13:   res = 4'd7;
            4'd15:   res = 4'd13;
            default: res = idx;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/vvou_occ_store.sv =====
// Single-port occupancy memory with a clearing pass after reset.
`default_nettype none

module vvou_occ_store #(
    parameter int AW = $clog2(vvou_pkg::VVOU_EDGE)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_we,
    input  wire logic            i_wd,
    input  wire logic [3*AW-1:0] i_addr,
    output logic                 o_rd,
    output logic                 o_busy
);
    import vvou_pkg::*;

    localparam int DEPTH = 1 << (3 * AW);

    logic            r_mem [DEPTH];
    logic [3*AW-1:0] r_clr_addr;
    logic            r_clr_busy;
    logic [3*AW-1:0] w_addr;
    logic            w_we;
    logic            w_wd;

    // The sweep owns the port until every entry has been cleared.
    assign w_addr = r_clr_busy ? r_clr_addr : i_addr;
    assign w_we   = r_clr_busy | i_we;
    assign w_wd   = r_clr_busy ? 1'b0 : i_wd;

    // Clearing pass counter, one entry per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // Memory array with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wd;
        end
        o_rd <= r_mem[w_addr];
    end

    assign o_busy = r_clr_busy;

endmodule

`default_nettype wire

// ===== rtl/core/voxel_visibility_occlusion_unit_core.sv =====
// Top level of the voxel visibility and occlusion unit.
// Keeps an EDGE^3 cube of occupancy bits in a single-port memory and runs one command at a
// time through a small sequencer that shares one coordinate adder and bounds check. After
// reset the memory is swept clear, one entry per cycle, over all 2^(3*clog2(EDGE)) entries
// (32768 at the default edge of 32); no command is taken during the sweep. A command then
// runs through the sequencer: a write state for set or clear, or for a query a state that
// reads the voxel itself, one neighbour state per walk step and a drain state (an occlusion
// query with an unused face code skips the neighbour steps), then a done state that loads
// the output register; the next command can be taken once its result is shown. The memory
// port reads the voxel and then one neighbour per cycle. A finished result sits in an output
// register, so it can wait on a stalled consumer while the block works on the next command.
`default_nettype none

module voxel_visibility_occlusion_unit_core #(
    parameter int EDGE = vvou_pkg::VVOU_EDGE
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_opcode,
    input  wire logic [4:0] i_pos_x,
    input  wire logic [4:0] i_pos_y,
    input  wire logic [4:0] i_pos_z,
    input  wire logic [2:0] i_face,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic            o_block_active,
    output logic            o_visible,
    output logic [7:0]      o_neighbour_map,
    output logic [3:0]      o_tile_column,
    output logic [3:0]      o_tile_row
);
    import vvou_pkg::*;

    localparam int AW = $clog2(EDGE);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WRITE = 6'b000010,
        S_SELF  = 6'b000100,
        S_NBR   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    t_opcode     r_op;
    logic [4:0]  r_x, r_y, r_z;
    logic [2:0]  r_face;
    logic [2:0]  r_k;
    logic [7:0]  r_map;
    logic        r_act;
    logic        r_pv, r_pself, r_pin;
    logic [2:0]  r_pk;
    logic        r_ovalid;
    logic        r_o_act, r_o_vis;
    logic [7:0]  r_o_map;
    logic [3:0]  r_o_col, r_o_row;

    logic            w_accept;
    logic            w_busy;
    logic            w_rd;
    t_ofs            w_ofs;
    logic [CW-1:0]   w_cx, w_cy, w_cz;
    logic            w_cin;
    logic [3*AW-1:0] w_addr;
    logic            w_we;
    logic            w_issue;
    logic [2:0]      w_klast;
    logic            w_slot_free;
    logic            w_self_in;
    logic            w_border;
    logic            w_res_vis;
    logic [7:0]      w_res_map;

    assign o_stall  = (r_state != S_IDLE) | w_busy;
    assign w_accept = i_valid & ~o_stall;

    // Offset for the current step: zero for the voxel itself.
    always_comb begin
        w_ofs = '0;
        if (r_state == S_NBR) begin
            if (r_op == OP_VIS) begin
                w_ofs = VIS_OFS[r_k];
            end else begin
                w_ofs = RING_OFS[r_face][r_k];
            end
        end
    end

    // Shared coordinate adder and bounds check.
    assign w_cx  = CW'(r_x) + {{(CW-2){w_ofs[5]}}, w_ofs[5:4]};
    assign w_cy  = CW'(r_y) + {{(CW-2){w_ofs[3]}}, w_ofs[3:2]};
    assign w_cz  = CW'(r_z) + {{(CW-2){w_ofs[1]}}, w_ofs[1:0]};
    assign w_cin = (w_cx < CW'(EDGE)) & (w_cy < CW'(EDGE)) & (w_cz < CW'(EDGE));
    assign w_addr = {w_cx[AW-1:0], w_cy[AW-1:0], w_cz[AW-1:0]};
    assign w_we   = (r_state == S_WRITE) & w_cin;
    assign w_issue = (r_state == S_SELF) | (r_state == S_NBR);
    assign w_klast = (r_op == OP_VIS) ? VIS_LAST : RING_LAST;

    vvou_occ_store #(
        .AW (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_we),
        .i_wd    (r_op == OP_SET),
        .i_addr  (w_addr),
        .o_rd    (w_rd),
        .o_busy  (w_busy)
    );

    // Result of the finished command.
    assign w_self_in = (CW'(r_x) < CW'(EDGE)) & (CW'(r_y) < CW'(EDGE)) &
                       (CW'(r_z) < CW'(EDGE));
    assign w_border  = ~w_self_in | (r_x == 5'd0) | (r_y == 5'd0) | (r_z == 5'd0) |
                       (CW'(r_x) == CW'(EDGE - 1)) | (CW'(r_y) == CW'(EDGE - 1)) |
                       (CW'(r_z) == CW'(EDGE - 1));
    assign w_res_vis = (r_op == OP_VIS) & (w_border | ~(&r_map[5:0]));
    assign w_res_map = (r_op == OP_OCC) ? r_map : 8'd0;
    assign w_slot_free = ~r_ovalid | ~i_stall;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_opcode inside {OP_SET, OP_CLEAR}) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_SELF;
                    end
                end
            end
            S_WRITE: n_state = S_DONE;
            S_SELF: begin
                if (r_op == OP_VIS || 32'(r_face) < NUM_FACES) begin
                    n_state = S_NBR;
                end else begin
                    n_state = S_DRAIN;
                end
            end
            S_NBR: begin
                if (r_k == w_klast) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pv    <= w_issue;
            if (r_state == S_DONE && w_slot_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Command capture, step counter and collection of read bits.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= t_opcode'(i_opcode);
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
            r_face <= i_face;
            r_map  <= '0;
            r_act  <= 1'b0;
        end else begin
            if (r_state == S_WRITE) begin
                r_act <= w_cin & (r_op == OP_SET);
            end
            if (r_pv) begin
                if (r_pself) begin
                    r_act <= w_rd & r_pin;
                end else begin
                    r_map[r_pk] <= w_rd & r_pin;
                end
            end
        end
        if (r_state == S_NBR) begin
            r_k <= r_k + 3'd1;
        end else begin
            r_k <= '0;
        end
        r_pself <= (r_state == S_SELF);
        r_pk    <= r_k;
        r_pin   <= w_cin;
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_slot_free) begin
            r_o_act <= r_act;
            r_o_vis <= w_res_vis;
            r_o_map <= w_res_map;
            r_o_col <= {w_res_map[7], w_res_map[2], w_res_map[1], w_res_map[0]};
            r_o_row <= row_lookup({w_res_map[4], w_res_map[5], w_res_map[6], w_res_map[3]});
        end
    end

    assign o_valid         = r_ovalid;
    assign o_block_active  = r_o_act;
    assign o_visible       = r_o_vis;
    assign o_neighbour_map = r_o_map;
    assign o_tile_column   = r_o_col;
    assign o_tile_row      = r_o_row;

endmodule

`default_nettype wire

// ===== rtl/core/vvou_chk.sv =====
// Port-level checker for the voxel visibility and occlusion unit, with its bind.
`default_nettype none

module vvou_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic [1:0] i_opcode,
    input wire logic [4:0] i_pos_x,
    input wire logic [4:0] i_pos_y,
    input wire logic [4:0] i_pos_z,
    input wire logic [2:0] i_face,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic       o_block_active,
    input wire logic       o_visible,
    input wire logic [7:0] o_neighbour_map,
    input wire logic [3:0] o_tile_column,
    input wire logic [3:0] o_tile_row
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_block_active, o_visible,
            o_neighbour_map, o_tile_column, o_tile_row}))
        else $error("stalled result changed");

    // Every command keeps the block busy in the cycle after its transfer.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken back to back");

    // A result with the visible flag set never carries a neighbour map.
    a_vis_no_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_visible && o_neighbour_map != 8'd0))
        else $error("visible flag with neighbour map");

    // The column tile follows ring bits 7, 2, 1 and 0 of the neighbour map.
    a_col_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tile_column == {o_neighbour_map[7], o_neighbour_map[2],
            o_neighbour_map[1], o_neighbour_map[0]})
        else $error("tile column disagrees with neighbour map");

    // No result is shown right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind voxel_visibility_occlusion_unit_core vvou_chk u_vvou_chk (.*);

`default_nettype wire
